### design/lrupt_pkg.sv
// shared constants for the lru page table with pinning
// field widths, mode and status codes, parameter defaults; no dependencies
package lrupt_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int ID_BITS_DEF = 32;

	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int FRAME_W  = 4;
	localparam int PIN_W    = 16;
	localparam int OUT_ID_W = 32;

	localparam logic [MODE_W-1:0] MODE_TOUCH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

### design/lrupt_ram.sv
// entry store of the lru page table: one write port, one read port
// read data is registered; depends on nothing else
module lrupt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/lru_page_table_with_pinning.sv
// lru page table with pinned frames, top level
// uses lrupt_pkg and the entry store lrupt_ram
//
//   channel | handshake          | beat
//   in      | in_valid, in_stall | mode, page_id, frame_in, pinned_mask
//   out     | out_valid, out_stall | status, out_page_id, out_frame
//
// after the accepted beat one pass over the entry store walks the entries held, up
// to ENTRIES; the result is then loaded into the output register once that register
// is free, and the next beat can be taken in the cycle after the load; the pass reads
// one entry per cycle through its read port, found entry dropped by writing
// each later entry one slot down in the same pass
// in_stall is high from the accepted beat until the result is loaded into the
// output register; the result waits there while the next item is taken
// reset clears the entry count and control state; the store itself is not cleared
module lru_page_table_with_pinning
	import lrupt_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [31:0]         page_id,
	input  logic [FRAME_W-1:0]  frame_in,
	input  logic [PIN_W-1:0]    pinned_mask,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [OUT_ID_W-1:0] out_page_id,
	output logic [FRAME_W-1:0]  out_frame
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = ID_BITS + FRAME_W;
	localparam int EXT_W = (ID_BITS > OUT_ID_W) ? ID_BITS : OUT_ID_W;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_WALK   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               found_q;
	logic               out_valid_q;

	logic [MODE_W-1:0]  mode_q;
	logic [ID_BITS-1:0] id_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PIN_W-1:0]   pin_q;
	logic [ID_BITS-1:0] hit_page_q;
	logic [FRAME_W-1:0] hit_frame_q;

	logic [STATUS_W-1:0] status_q;
	logic [OUT_ID_W-1:0] out_page_q;
	logic [FRAME_W-1:0]  out_frame_q;

	logic [EXT_W-1:0]   id_ext;
	logic [EXT_W-1:0]   page_ext;
	logic [ID_BITS-1:0] id_in;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENT_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENT_W-1:0]   ram_rdata;

	logic [ID_BITS-1:0] rd_page;
	logic [FRAME_W-1:0] rd_frame;
	logic               hit;
	logic               in_acc;
	logic               walk_done;
	logic               fin_go;
	logic [CNT_W-1:0]   cnt_after;
	logic               append;
	logic               is_touch;
	logic               is_victim;
	logic               is_remove;

	lrupt_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign id_ext   = EXT_W'(page_id);
	assign id_in    = id_ext[ID_BITS-1:0];
	assign page_ext = EXT_W'(hit_page_q);

	assign rd_page  = ram_rdata[ENT_W-1:FRAME_W];
	assign rd_frame = ram_rdata[FRAME_W-1:0];

	assign is_touch  = (mode_q == MODE_TOUCH);
	assign is_victim = (mode_q == MODE_VICTIM);
	assign is_remove = (mode_q == MODE_REMOVE);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// one entry per cycle; entries after a hit move down one slot
	assign ram_re    = (state_q == S_WALK) && (rd_idx_q < count_q);
	assign ram_raddr = rd_idx_q[IDX_W-1:0];

	assign hit = v_s1 && !found_q &&
		(((is_touch || is_remove) && (rd_page == id_q)) ||
		 (is_victim && !pin_q[rd_frame]));

	assign walk_done = (state_q == S_WALK) && !v_s1 && !ram_re;

	assign fin_go    = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign cnt_after = found_q ? (count_q - CNT_W'(1)) : count_q;
	assign append    = is_touch && (cnt_after < CNT_W'(ENTRIES));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1 - IDX_W'(1);
		ram_wdata = ram_rdata;
		if (state_q == S_WALK && v_s1 && found_q) begin
			ram_we = 1'b1;
		end else if (fin_go && append) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_after[IDX_W-1:0];
			ram_wdata = {id_q, frame_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rd_idx_q <= '0;
						v_s1     <= 1'b0;
						found_q  <= 1'b0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					v_s1 <= ram_re;
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (walk_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						count_q <= append ? (cnt_after + CNT_W'(1)) : cnt_after;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q  <= mode;
			id_q    <= id_in;
			frame_q <= frame_in;
			pin_q   <= pinned_mask;
		end
		if (state_q == S_WALK) begin
			idx_s1 <= ram_raddr;
		end
		if (hit) begin
			hit_page_q  <= rd_page;
			hit_frame_q <= rd_frame;
		end
		if (fin_go) begin
			if (is_touch) begin
				status_q    <= append ? ST_DONE : ST_FULL;
				out_page_q  <= '0;
				out_frame_q <= '0;
			end else if ((is_victim || is_remove) && found_q) begin
				status_q    <= ST_DONE;
				out_frame_q <= hit_frame_q;
				out_page_q  <= is_victim ? page_ext[OUT_ID_W-1:0] : '0;
			end else begin
				status_q    <= ST_MISS;
				out_page_q  <= '0;
				out_frame_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_page_id = out_page_q;
	assign out_frame   = out_frame_q;

endmodule

### design/lrupt_checker.sv
// port-level checks for the lru page table, bound to the top level
// uses lrupt_pkg for field widths and status codes
module lrupt_checker
	import lrupt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [OUT_ID_W-1:0] out_page_id,
	input logic [FRAME_W-1:0]  out_frame
);

	// a held result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
			$stable(out_page_id) && $stable(out_frame))
	else $error("held result beat changed");

	// after an accepted beat the input side is busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("input taken again right after a beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_MISS || status == ST_FULL))
	else $error("unknown status code");

	// failed or full results carry no page and no frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> out_page_id == '0 && out_frame == '0)
	else $error("payload on a failed result");

endmodule

bind lru_page_table_with_pinning lrupt_checker u_lrupt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.out_page_id (out_page_id),
	.out_frame   (out_frame)
);

### tb/sv/lrupt_checker.sv
`timescale 1ns / 1ps
// result checker for the lru page table with pinning: models the recency table
// from the accepted input beats and compares every output beat in order
// depends on lrupt_pkg
module lrupt_monitor
	import lrupt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [31:0]         page_id,
	input  logic [FRAME_W-1:0]  frame_in,
	input  logic [PIN_W-1:0]    pinned_mask,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [OUT_ID_W-1:0] out_page_id,
	input  logic [FRAME_W-1:0]  out_frame,
	output int                  fail_count,
	output int                  pending
);

	localparam int ENTRIES = ENTRIES_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OUT_ID_W-1:0] page;
		logic [FRAME_W-1:0]  frame;
	} lru_result_t;

	logic [31:0]        tbl_page [ENTRIES];
	logic [FRAME_W-1:0] tbl_frame [ENTRIES];
	int                 held = 0;
	int                 fails = 0;
	lru_result_t        result_q [$];
	lru_result_t        want;
	lru_result_t        next_want;

	function automatic int find_slot(input logic [31:0] id);
		int pos;
		pos = -1;
		for (int k = held - 1; k >= 0; k--)
			if (tbl_page[k] == id)
				pos = k;
		return pos;
	endfunction

	function automatic void drop_slot(input int slot);
		for (int k = slot; k + 1 < held; k++) begin
			tbl_page[k] = tbl_page[k + 1];
			tbl_frame[k] = tbl_frame[k + 1];
		end
		held--;
	endfunction

	task automatic predict_lookup(
		input  logic [MODE_W-1:0]  m,
		input  logic [31:0]        id,
		input  logic [FRAME_W-1:0] fr,
		input  logic [PIN_W-1:0]   pin,
		output lru_result_t        r
	);
		int  pos;
		bit  found;
		r.status = ST_MISS;
		r.page = '0;
		r.frame = '0;
		found = 0;
		case (m)
			MODE_TOUCH: begin
				pos = find_slot(id);
				if (pos >= 0)
					drop_slot(pos);
				if (held >= ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					tbl_page[held] = id;
					tbl_frame[held] = fr;
					held++;
					r.status = ST_DONE;
				end
			end
			MODE_VICTIM: begin
				for (int k = 0; k < held && !found; k++) begin
					if (!pin[tbl_frame[k]]) begin
						r.status = ST_DONE;
						r.page = tbl_page[k];
						r.frame = tbl_frame[k];
						drop_slot(k);
						found = 1;
					end
				end
			end
			MODE_REMOVE: begin
				pos = find_slot(id);
				if (pos >= 0) begin
					r.status = ST_DONE;
					r.frame = tbl_frame[pos];
					drop_slot(pos);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			result_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected beat: status %0d page %h frame %0d",
						$time, status, out_page_id, out_frame);
				end else begin
					want = result_q.pop_front();
					if (status !== want.status) begin
						fails++;
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
					end
					if (out_page_id !== want.page) begin
						fails++;
						$display("%0t: out_page_id expected %h got %h",
							$time, want.page, out_page_id);
					end
					if (out_frame !== want.frame) begin
						fails++;
						$display("%0t: out_frame expected %0d got %0d",
							$time, want.frame, out_frame);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_lookup(mode, page_id, frame_in, pinned_mask, next_want);
				result_q = {result_q, next_want};
			end
		end
		fail_count <= fails;
		pending <= result_q.size();
	end

endmodule

### tb/sv/tb_lru_page_table_with_pinning.sv
`timescale 1ns / 1ps
// testbench top for the lru page table with pinning: clock, reset, beat stimulus,
// receiver stalls, watchdog and verdict; depends on lrupt_pkg, lrupt_monitor and the block
module tb_lru_page_table_with_pinning;
	import lrupt_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 130;
	localparam int POOL_SIZE    = 24;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [MODE_W-1:0]   mode;
	logic [31:0]         page_id;
	logic [FRAME_W-1:0]  frame_in;
	logic [PIN_W-1:0]    pinned_mask;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [OUT_ID_W-1:0] out_page_id;
	logic [FRAME_W-1:0]  out_frame;

	int          fail_count;
	int          pending;
	int          snd_idle_pct = 0;
	int          rcv_stall_pct = 0;
	bit          hold_req = 0;
	bit          hold_taken = 0;
	int          hold_left;
	int          quiet;
	logic [31:0] id_pool [POOL_SIZE];

	lru_page_table_with_pinning DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.page_id     (page_id),
		.frame_in    (frame_in),
		.pinned_mask (pinned_mask),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_page_id (out_page_id),
		.out_frame   (out_frame)
	);

	lrupt_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.page_id     (page_id),
		.frame_in    (frame_in),
		.pinned_mask (pinned_mask),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_page_id (out_page_id),
		.out_frame   (out_frame),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	task automatic put_beat(
		input logic [MODE_W-1:0]  m,
		input logic [31:0]        id,
		input logic [FRAME_W-1:0] fr,
		input logic [PIN_W-1:0]   pin
	);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		page_id <= id;
		frame_in <= fr;
		pinned_mask <= pin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [PIN_W-1:0] pick_mask();
		logic [PIN_W-1:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			2, 3: v = PIN_W'($urandom);
			4: v = PIN_W'($urandom | $urandom);
			default: v = PIN_W'($urandom & $urandom);
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_id();
		if ($urandom_range(99) < 85)
			return id_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic random_beat();
		int               r;
		logic [MODE_W-1:0] m;
		r = $urandom_range(99);
		if (r < 50)
			m = MODE_TOUCH;
		else if (r < 75)
			m = MODE_VICTIM;
		else if (r < 95)
			m = MODE_REMOVE;
		else
			m = MODE_UNUSED;
		put_beat(m, pick_id(), FRAME_W'($urandom_range(15)), pick_mask());
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_TOUCH;
		page_id <= '0;
		frame_in <= '0;
		pinned_mask <= '0;
		foreach (id_pool[i])
			id_pool[i] = $urandom;
		id_pool[0] = '0;
		id_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, unused mode
		put_beat(MODE_VICTIM, '0, '0, '0);
		put_beat(MODE_REMOVE, '1, '0, '0);
		put_beat(MODE_UNUSED, 32'h1234_5678, '1, '1);
		// extremes, then a known page moves to most recent
		put_beat(MODE_TOUCH, '0, '0, '0);
		put_beat(MODE_TOUCH, '1, '1, '0);
		put_beat(MODE_TOUCH, '0, 4'h1, '0);
		for (int k = 2; k < 16; k++)
			put_beat(MODE_TOUCH, id_pool[k], FRAME_W'(k), '0);
		// full table: new page refused, known page still moves
		put_beat(MODE_TOUCH, id_pool[16], 4'h3, '0);
		put_beat(MODE_TOUCH, '1, 4'hE, '0);
		put_beat(MODE_VICTIM, '0, '0, '1);
		put_beat(MODE_VICTIM, '0, '0, 16'h0002);
		put_beat(MODE_REMOVE, id_pool[5], '0, '1);
		put_beat(MODE_REMOVE, id_pool[20], '0, '0);
		wait_results_done();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 75; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 75; end
				default: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 20)
					hold_req = 1;
				if (ph == 3 && n == 70)
					wait_results_done();
				random_beat();
			end
			wait_results_done();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
